@@ hdl/rbs_pkg.sv @@
`default_nettype none

package rbs_pkg;

    // Router test states
    localparam logic [2:0] ST_NORMAL  = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_TESTING = 3'd2;
    localparam logic [2:0] ST_RECOVER = 3'd3;
    localparam logic [2:0] ST_FREE    = 3'd4;
    localparam logic [2:0] ST_BLOCK   = 3'd5;

    // Test modes
    localparam logic [1:0] MODE_TARRA    = 2'd0;
    localparam logic [1:0] MODE_BLOCKING = 2'd1;
    localparam logic [1:0] MODE_NONBLOCK = 2'd2;
    localparam logic [1:0] MODE_FREESLOT = 2'd3;

    // Port view codes
    localparam logic [1:0] VIEW_NORMAL = 2'd0;
    localparam logic [1:0] VIEW_EMPTY  = 2'd1;
    localparam logic [1:0] VIEW_FREE   = 2'd2;
    localparam logic [1:0] VIEW_BLOCK  = 2'd3;

    // Fault actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_INJECT  = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // Command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_INTERVAL  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_DURATION  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREE_SLOT_TIME = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_TIME     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORDER_OFFSET   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROUTER_X       = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROUTER_Y       = 3'd7;

    // Field widths
    localparam int CFG_DATA_W = 24;
    localparam int TIME_W     = 24;
    localparam int INTV_CNT_W = 32;
    localparam int OFFSET_W   = 12;
    localparam int COORD_W    = 6;
    localparam int PORT_W     = 5;
    // Holds order plus offset for the largest mesh
    localparam int SUM_W      = 14;

    // Reset values
    localparam logic [1:0]        RST_TEST_MODE      = MODE_TARRA;
    localparam logic [TIME_W-1:0] RST_TEST_INTERVAL  = 24'd100000;
    localparam logic [TIME_W-1:0] RST_TEST_DURATION  = 24'd1000;
    localparam logic [TIME_W-1:0] RST_FREE_SLOT_TIME = 24'd100;
    localparam logic [TIME_W-1:0] RST_BLOCK_TIME     = 24'd100;

    // Cycles the derived schedule registers need after a config write
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

    typedef struct packed {
        logic              command;
        logic [PORT_W-1:0] in_buffers_empty;
        logic [PORT_W-1:0] out_buffers_empty;
        logic [PORT_W-1:0] neighbor_ack;
    } rbs_in_t;

    typedef struct packed {
        logic [2:0] router_state;
        logic [1:0] port_view;
        logic [1:0] router_fault_action;
        logic [1:0] port_fault_action;
        logic       drain_started;
        logic       recover_started;
        logic       drain_cycle;
        logic       recover_cycle;
    } rbs_out_t;

endpackage

`default_nettype wire

@@ hdl/router_bist_scheduler_top.sv @@
// Online self-test scheduler for one router of a mesh network-on-chip. Each request is
// either a tick (one router clock) or a schedule load that presets the interval timer to
// this router's staggered start; every request returns exactly one result with the router
// state after the step, the port view, fault inject/release actions and statistic pulses.
// Requests pass through an input register and a result register, one request per cycle
// unless m_ready stalls the result or the chain below settles; the next-state logic is a
// single pass over the state and timer registers. The staggered start value is kept
// precomputed from the configuration registers in a four-stage chain (reciprocal
// multiplies for the divisions by the router count), so after every configuration write
// and after reset s_ready stays low while that chain settles. cfg_ready is always high.
`default_nettype none

module router_bist_scheduler_top
    import rbs_pkg::*;
#(
    parameter int MESH_X = 8,
    parameter int MESH_Y = 8,
    parameter int PORTS  = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rbs_in_t               s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rbs_out_t                   m_data,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COUNT  = MESH_X * MESH_Y;
    localparam int CNT_L  = $clog2(COUNT);
    localparam int CNT_W  = $clog2(COUNT + 1);
    // (g * COUNT) / 4 for the four 2x2 groups
    localparam logic [SUM_W-1:0] GROUP1_BASE = SUM_W'(COUNT / 4);
    localparam logic [SUM_W-1:0] GROUP2_BASE = SUM_W'((2 * COUNT) / 4);
    localparam logic [SUM_W-1:0] GROUP3_BASE = SUM_W'((3 * COUNT) / 4);
    // Reciprocals: floor(v / COUNT) = (v * ceil(2^(N+L) / COUNT)) >> (N+L), exact for v < 2^N
    localparam int INTV_SHIFT = TIME_W + CNT_L;
    localparam int INTV_PW    = 2 * TIME_W + 1;
    localparam longint unsigned INTV_RECIP =
        ((64'd1 << INTV_SHIFT) + 64'(COUNT) - 64'd1) / 64'(COUNT);
    localparam int SUM_SHIFT  = SUM_W + CNT_L;
    localparam int SUM_PW     = 2 * SUM_W + 1;
    localparam longint unsigned SUM_RECIP =
        ((64'd1 << SUM_SHIFT) + 64'(COUNT) - 64'd1) / 64'(COUNT);
    localparam int LOAD_PW    = TIME_W + CNT_W;
    localparam logic [PORT_W-1:0] PORT_MASK = PORT_W'((1 << PORTS) - 1);

    // configuration registers
    logic [1:0]          test_mode_reg;
    logic [TIME_W-1:0]   test_interval_reg;
    logic [TIME_W-1:0]   test_duration_reg;
    logic [TIME_W-1:0]   free_slot_time_reg;
    logic [TIME_W-1:0]   block_time_reg;
    logic [OFFSET_W-1:0] order_offset_reg;
    logic [COORD_W-1:0]  router_x_reg;
    logic [COORD_W-1:0]  router_y_reg;
    logic [2:0]          settle_reg;

    // schedule chain
    logic [SUM_W-1:0]    group_base;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [INTV_PW-1:0]  intv_prod;
    logic [TIME_W-1:0]   slot_reg;
    logic [SUM_PW-1:0]   sum_prod;
    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    rot;
    logic [CNT_W-1:0]    rot_p1_reg;
    logic [LOAD_PW-1:0]  load_prod;
    logic [TIME_W-1:0]   load_reg;

    // pipeline
    logic                in_valid_reg;
    rbs_in_t             in_reg;
    logic                advance;
    logic                m_valid_reg;
    rbs_out_t            m_data_reg;

    // scheduler state
    logic [2:0]            mode_state_reg;
    logic [2:0]            mode_state_next;
    logic [INTV_CNT_W-1:0] interval_count_reg;
    logic [INTV_CNT_W-1:0] interval_count_next;
    logic [INTV_CNT_W-1:0] interval_inc;
    logic [TIME_W-1:0]     duration_count_reg;
    logic [TIME_W-1:0]     duration_count_next;
    logic [TIME_W-1:0]     duration_inc;
    logic                  ports_empty;
    rbs_out_t              res_next;

    assign cfg_ready = 1'b1;

    // Configuration writes; the settle counter holds off requests until the chain is fresh
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_mode_reg      <= RST_TEST_MODE;
            test_interval_reg  <= RST_TEST_INTERVAL;
            test_duration_reg  <= RST_TEST_DURATION;
            free_slot_time_reg <= RST_FREE_SLOT_TIME;
            block_time_reg     <= RST_BLOCK_TIME;
            order_offset_reg   <= '0;
            router_x_reg       <= '0;
            router_y_reg       <= '0;
            settle_reg         <= SETTLE_CYCLES;
        end else if (cfg_valid && cfg_ready) begin
            settle_reg <= SETTLE_CYCLES;
            case (cfg_addr)
                CFG_TEST_MODE:      test_mode_reg      <= cfg_data[1:0];
                CFG_TEST_INTERVAL:  test_interval_reg  <= cfg_data[TIME_W-1:0];
                CFG_TEST_DURATION:  test_duration_reg  <= cfg_data[TIME_W-1:0];
                CFG_FREE_SLOT_TIME: free_slot_time_reg <= cfg_data[TIME_W-1:0];
                CFG_BLOCK_TIME:     block_time_reg     <= cfg_data[TIME_W-1:0];
                CFG_ORDER_OFFSET:   order_offset_reg   <= cfg_data[OFFSET_W-1:0];
                CFG_ROUTER_X:       router_x_reg       <= cfg_data[COORD_W-1:0];
                CFG_ROUTER_Y:       router_y_reg       <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    // Group base from the 2x2 position
    always_comb begin
        case ({router_y_reg[0], router_x_reg[0]})
            2'd1:    group_base = GROUP1_BASE;
            2'd2:    group_base = GROUP2_BASE;
            2'd3:    group_base = GROUP3_BASE;
            default: group_base = '0;
        endcase
    end

    // Test order plus rotation, before the modulo
    assign sum_next = SUM_W'(router_x_reg[COORD_W-1:1])
                    + SUM_W'((SUM_W'(router_y_reg[COORD_W-1:1]) * SUM_W'(MESH_X)) >> 1)
                    + group_base
                    + SUM_W'(order_offset_reg);

    assign intv_prod = INTV_PW'(test_interval_reg) * INTV_PW'(INTV_RECIP);
    assign sum_prod  = SUM_PW'(sum_reg) * SUM_PW'(SUM_RECIP);
    assign rot       = sum_reg - SUM_W'(quo_reg * SUM_W'(COUNT));
    assign load_prod = LOAD_PW'(slot_reg) * LOAD_PW'(rot_p1_reg);

    // Staggered start chain: slot = interval / count, rot = sum % count,
    // start = interval - slot * (rot + 1)
    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        slot_reg   <= TIME_W'(intv_prod >> INTV_SHIFT);
        quo_reg    <= SUM_W'(sum_prod >> SUM_SHIFT);
        rot_p1_reg <= CNT_W'(rot) + CNT_W'(1);
        load_reg   <= test_interval_reg - TIME_W'(load_prod);
    end

    // Handshake
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = (settle_reg == '0) && (!in_valid_reg || advance);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Saturating timers and drain check over the active ports
    assign interval_inc = (interval_count_reg == '1) ? interval_count_reg
                                                     : interval_count_reg + 1'b1;
    assign duration_inc = (duration_count_reg == '1) ? duration_count_reg
                                                     : duration_count_reg + 1'b1;
    assign ports_empty  = (&(in_reg.in_buffers_empty  | ~PORT_MASK))
                       && (&(in_reg.out_buffers_empty | ~PORT_MASK))
                       && (&(in_reg.neighbor_ack      | ~PORT_MASK));

    // Next state and result
    always_comb begin
        mode_state_next     = mode_state_reg;
        interval_count_next = interval_count_reg;
        duration_count_next = duration_count_reg;
        res_next            = '0;

        if (in_reg.command == CMD_LOAD) begin
            interval_count_next = INTV_CNT_W'(load_reg);
        end else begin
            interval_count_next = interval_inc;
            case (mode_state_reg)
                ST_NORMAL: begin
                    if (interval_inc >= INTV_CNT_W'(test_interval_reg)) begin
                        interval_count_next = '0;
                        if (test_mode_reg == MODE_TARRA) begin
                            mode_state_next = ST_EMPTY;
                        end else if (test_mode_reg == MODE_BLOCKING) begin
                            mode_state_next     = ST_TESTING;
                            duration_count_next = '0;
                        end else begin
                            mode_state_next     = ST_FREE;
                            duration_count_next = '0;
                        end
                    end
                end
                ST_EMPTY: begin
                    res_next.drain_cycle = 1'b1;
                    if (ports_empty) begin
                        duration_count_next = '0;
                        mode_state_next     = ST_TESTING;
                    end
                end
                ST_TESTING: begin
                    duration_count_next = duration_inc;
                    if (duration_inc >= test_duration_reg) begin
                        duration_count_next = '0;
                        if (test_mode_reg inside {MODE_BLOCKING, MODE_FREESLOT}) begin
                            mode_state_next = ST_NORMAL;
                        end else begin
                            mode_state_next = ST_RECOVER;
                        end
                    end
                end
                ST_RECOVER: begin
                    res_next.recover_cycle = 1'b1;
                    if (ports_empty) begin
                        mode_state_next = ST_NORMAL;
                    end
                end
                ST_FREE: begin
                    duration_count_next = duration_inc;
                    if (duration_inc >= free_slot_time_reg) begin
                        duration_count_next = '0;
                        mode_state_next     = ST_BLOCK;
                    end
                end
                ST_BLOCK: begin
                    duration_count_next = duration_inc;
                    if (duration_inc >= block_time_reg) begin
                        duration_count_next = '0;
                        mode_state_next = (test_mode_reg == MODE_NONBLOCK) ? ST_EMPTY
                                                                           : ST_TESTING;
                    end
                end
                default: ;
            endcase

            // actions and pulses on a state change
            if (mode_state_next != mode_state_reg) begin
                case (mode_state_next)
                    ST_TESTING: begin
                        res_next.router_fault_action = ACT_INJECT;
                        res_next.port_fault_action   = ACT_RELEASE;
                    end
                    ST_NORMAL: begin
                        res_next.router_fault_action = ACT_RELEASE;
                        res_next.port_fault_action   = ACT_RELEASE;
                    end
                    ST_EMPTY: begin
                        res_next.port_fault_action = ACT_INJECT;
                        res_next.drain_started     = 1'b1;
                    end
                    ST_RECOVER: begin
                        res_next.port_fault_action = ACT_INJECT;
                        res_next.recover_started   = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        res_next.router_state = mode_state_next;
        if (test_mode_reg == MODE_BLOCKING) begin
            res_next.port_view = VIEW_NORMAL;
        end else begin
            case (mode_state_next)
                ST_EMPTY, ST_RECOVER: res_next.port_view = VIEW_EMPTY;
                ST_FREE:              res_next.port_view = VIEW_FREE;
                ST_BLOCK:             res_next.port_view = VIEW_BLOCK;
                default:              res_next.port_view = VIEW_NORMAL;
            endcase
        end
    end

    // Scheduler state, stepped as a request leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_state_reg     <= ST_NORMAL;
            interval_count_reg <= '0;
            duration_count_reg <= '0;
        end else if (advance) begin
            mode_state_reg     <= mode_state_next;
            interval_count_reg <= interval_count_next;
            duration_count_reg <= duration_count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rbs_checker.sv @@
`default_nettype none

module rbs_checker
    import rbs_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire rbs_out_t m_data,
    input wire logic     cfg_valid,
    input wire logic     cfg_ready
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // requests are held off right after a config write
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("request taken while schedule settles");

    // router fault release only on return to normal, with port release
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.router_fault_action == ACT_RELEASE)
        |-> (m_data.router_state == ST_NORMAL) && (m_data.port_fault_action == ACT_RELEASE))
        else $error("router release outside return to normal");

    // drain start pulse matches entry into empty with port injection
    a_drain_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.drain_started
        |-> (m_data.router_state == ST_EMPTY) && (m_data.port_fault_action == ACT_INJECT)
            && !m_data.drain_cycle)
        else $error("drain start pulse without empty entry");

endmodule

bind router_bist_scheduler_top rbs_checker u_rbs_checker (.*);

`default_nettype wire

@@ dv/router_bist_scheduler_checker.sv @@
module router_bist_scheduler_checker
    import rbs_pkg::*;
#(
    parameter int MESH_X = 8,
    parameter int MESH_Y = 8,
    parameter int PORTS  = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire rbs_in_t               s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire rbs_out_t              m_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROUTERS = MESH_X * MESH_Y;
    localparam logic [PORT_W-1:0] PORT_MASK = PORT_W'((1 << PORTS) - 1);

    // Shadow copy of the configuration registers
    logic [1:0]          mode_reg;
    logic [TIME_W-1:0]   interval_reg;
    logic [TIME_W-1:0]   duration_reg;
    logic [TIME_W-1:0]   free_slot_reg;
    logic [TIME_W-1:0]   block_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;

    // Shadow scheduler state
    logic [2:0]            sched_state;
    logic [INTV_CNT_W-1:0] interval_cnt;
    logic [TIME_W-1:0]     duration_cnt;

    // Router status awaited on the result channel, oldest first
    rbs_out_t awaited_status[$];
    int       errors;

    function automatic logic [1:0] view_of(input logic [2:0] st);
        if (mode_reg == MODE_BLOCKING) return VIEW_NORMAL;
        case (st)
            ST_EMPTY, ST_RECOVER: return VIEW_EMPTY;
            ST_FREE:              return VIEW_FREE;
            ST_BLOCK:             return VIEW_BLOCK;
            default:              return VIEW_NORMAL;
        endcase
    endfunction

    function automatic void bump_duration();
        if (duration_cnt != '1) duration_cnt++;
    endfunction

    // Advance the shadow scheduler by one request, return the status it reports
    function automatic rbs_out_t step_router(input rbs_in_t req);
        rbs_out_t    res;
        logic [2:0]  nxt;
        logic        drained;
        int unsigned xi, yi, order, rot, span;
        res = '0;
        res.router_fault_action = ACT_NONE;
        res.port_fault_action   = ACT_NONE;
        if (req.command == CMD_LOAD) begin
            // staggered start: 2x2 groups spread over the mesh, then rotated
            xi    = 32'(x_reg);
            yi    = 32'(y_reg);
            order = xi / 2 + ((yi / 2) * MESH_X) / 2 + (((yi % 2) * 2 + xi % 2) * ROUTERS) / 4;
            rot   = (order + 32'(offset_reg)) % ROUTERS;
            span  = 32'(interval_reg);
            interval_cnt = span - (span / ROUTERS) * (rot + 1);
        end else begin
            nxt     = sched_state;
            drained = ((req.in_buffers_empty & PORT_MASK) == PORT_MASK) &&
                      ((req.out_buffers_empty & PORT_MASK) == PORT_MASK) &&
                      ((req.neighbor_ack & PORT_MASK) == PORT_MASK);
            if (interval_cnt != '1) interval_cnt++;
            case (sched_state)
                ST_NORMAL: begin
                    if (interval_cnt >= INTV_CNT_W'(interval_reg)) begin
                        interval_cnt = '0;
                        if (mode_reg == MODE_TARRA) begin
                            nxt = ST_EMPTY;
                        end else if (mode_reg == MODE_BLOCKING) begin
                            nxt = ST_TESTING;
                            duration_cnt = '0;
                        end else begin
                            nxt = ST_FREE;
                            duration_cnt = '0;
                        end
                    end
                end
                ST_EMPTY: begin
                    res.drain_cycle = 1'b1;
                    if (drained) begin
                        duration_cnt = '0;
                        nxt = ST_TESTING;
                    end
                end
                ST_TESTING: begin
                    bump_duration();
                    if (duration_cnt >= duration_reg) begin
                        duration_cnt = '0;
                        if (mode_reg == MODE_BLOCKING || mode_reg == MODE_FREESLOT)
                            nxt = ST_NORMAL;
                        else
                            nxt = ST_RECOVER;
                    end
                end
                ST_RECOVER: begin
                    res.recover_cycle = 1'b1;
                    if (drained) nxt = ST_NORMAL;
                end
                ST_FREE: begin
                    bump_duration();
                    if (duration_cnt >= free_slot_reg) begin
                        duration_cnt = '0;
                        nxt = ST_BLOCK;
                    end
                end
                ST_BLOCK: begin
                    bump_duration();
                    if (duration_cnt >= block_reg) begin
                        duration_cnt = '0;
                        nxt = (mode_reg == MODE_NONBLOCK) ? ST_EMPTY : ST_TESTING;
                    end
                end
                default: ;
            endcase
            // actions and pulses only on a state change
            if (nxt != sched_state) begin
                if (nxt == ST_TESTING)
                    res.router_fault_action = ACT_INJECT;
                else if (nxt == ST_NORMAL)
                    res.router_fault_action = ACT_RELEASE;
                if (nxt == ST_EMPTY || nxt == ST_RECOVER)
                    res.port_fault_action = ACT_INJECT;
                else if (nxt == ST_TESTING || nxt == ST_NORMAL)
                    res.port_fault_action = ACT_RELEASE;
                res.drain_started   = (nxt == ST_EMPTY);
                res.recover_started = (nxt == ST_RECOVER);
                sched_state = nxt;
            end
        end
        res.router_state = sched_state;
        res.port_view    = view_of(sched_state);
        return res;
    endfunction

    always @(posedge aclk) begin
        rbs_out_t want;
        if (!aresetn) begin
            mode_reg      = RST_TEST_MODE;
            interval_reg  = RST_TEST_INTERVAL;
            duration_reg  = RST_TEST_DURATION;
            free_slot_reg = RST_FREE_SLOT_TIME;
            block_reg     = RST_BLOCK_TIME;
            offset_reg    = '0;
            x_reg         = '0;
            y_reg         = '0;
            sched_state   = ST_NORMAL;
            interval_cnt  = '0;
            duration_cnt  = '0;
            awaited_status.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_TEST_MODE:      mode_reg      = cfg_data[1:0];
                    CFG_TEST_INTERVAL:  interval_reg  = cfg_data;
                    CFG_TEST_DURATION:  duration_reg  = cfg_data;
                    CFG_FREE_SLOT_TIME: free_slot_reg = cfg_data;
                    CFG_BLOCK_TIME:     block_reg     = cfg_data;
                    CFG_ORDER_OFFSET:   offset_reg    = cfg_data[OFFSET_W-1:0];
                    CFG_ROUTER_X:       x_reg         = cfg_data[COORD_W-1:0];
                    CFG_ROUTER_Y:       y_reg         = cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            // compare a delivered status with the oldest one awaited
            if (m_valid && m_ready) begin
                if (awaited_status.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                    errors++;
                end else begin
                    want = awaited_status.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: result mismatch, expected %h, got %h",
                                 $time, want, m_data);
                        errors++;
                    end
                end
            end
            // predict the status for an accepted request
            if (s_valid && s_ready) awaited_status = {awaited_status, step_router(s_data)};
        end
        fail_count    <= errors;
        pending_count <= awaited_status.size();
    end

endmodule

@@ dv/router_bist_scheduler_top_tb.sv @@
module router_bist_scheduler_top_tb;
    import rbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MESH_X          = 8;
    localparam int MESH_Y          = 8;
    localparam int PORTS           = 5;
    localparam int PHASES          = 16;
    localparam int REQS_PER_PHASE  = 118;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic [1:0] MODE_CYCLE[4] = '{MODE_TARRA, MODE_BLOCKING,
                                             MODE_NONBLOCK, MODE_FREESLOT};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    rbs_in_t               s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_TEST_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire logic             s_ready;
    wire logic             m_valid;
    wire logic             cfg_ready;
    rbs_out_t              m_data;
    int                    fail_count;
    int                    pending_count;

    // Idle profile of the current phase, in percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // Long receiver hold-off, requested once by the stimulus
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int hold_off_left = 0;
    int quiet_cycles  = 0;

    router_bist_scheduler_top #(
        .MESH_X(MESH_X),
        .MESH_Y(MESH_Y),
        .PORTS (PORTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    router_bist_scheduler_checker #(
        .MESH_X(MESH_X),
        .MESH_Y(MESH_Y),
        .PORTS (PORTS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("router_bist_scheduler_top_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_schedule(input logic [1:0] mode, input logic [TIME_W-1:0] intv,
                                    input logic [TIME_W-1:0] dur,
                                    input logic [TIME_W-1:0] free_slot,
                                    input logic [TIME_W-1:0] blk,
                                    input logic [OFFSET_W-1:0] offs,
                                    input logic [COORD_W-1:0] rx,
                                    input logic [COORD_W-1:0] ry);
        write_reg(CFG_TEST_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_TEST_INTERVAL, intv);
        write_reg(CFG_TEST_DURATION, dur);
        write_reg(CFG_FREE_SLOT_TIME, free_slot);
        write_reg(CFG_BLOCK_TIME, blk);
        write_reg(CFG_ORDER_OFFSET, CFG_DATA_W'(offs));
        write_reg(CFG_ROUTER_X, CFG_DATA_W'(rx));
        write_reg(CFG_ROUTER_Y, CFG_DATA_W'(ry));
        cfg_valid <= 1'b0;
    endtask

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic send_req(input rbs_in_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every awaited status has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    function automatic rbs_in_t make_req(input logic cmd, input logic [PORT_W-1:0] ibe,
                                         input logic [PORT_W-1:0] obe,
                                         input logic [PORT_W-1:0] ack);
        rbs_in_t r;
        r.command           = cmd;
        r.in_buffers_empty  = ibe;
        r.out_buffers_empty = obe;
        r.neighbor_ack      = ack;
        return r;
    endfunction

    // Mostly ticks; buffers often fully drained so the drain and recover states exit
    function automatic rbs_in_t random_req();
        rbs_in_t    r;
        int         pick;
        logic [2:0] bit_idx;
        pick    = $urandom_range(99);
        bit_idx = 3'($urandom_range(PORT_W - 1));
        r = make_req((pick < 4) ? CMD_LOAD : CMD_TICK, PORT_W'($urandom),
                     PORT_W'($urandom), PORT_W'($urandom));
        if (pick >= 4 && pick < 55) begin
            r.in_buffers_empty  = '1;
            r.out_buffers_empty = '1;
            r.neighbor_ack      = '1;
            // one port still busy
            if (pick >= 40) begin
                case ($urandom_range(2))
                    0: r.in_buffers_empty[bit_idx] = 1'b0;
                    1: r.out_buffers_empty[bit_idx] = 1'b0;
                    default: r.neighbor_ack[bit_idx] = 1'b0;
                endcase
            end
        end
        return r;
    endfunction

    initial begin
        logic [1:0]          mode;
        logic [TIME_W-1:0]   intv, dur, free_slot, blk;
        logic [OFFSET_W-1:0] offs;
        logic [COORD_W-1:0]  rx, ry;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: largest router coordinates, largest offset, short timers, drain-test mode
        program_schedule(MODE_TARRA, 24'd3, '0, '0, '0, '1, '1, '1);
        send_req(make_req(CMD_LOAD, '0, '0, '0));
        send_req(make_req(CMD_LOAD, '1, '1, '1));
        send_req(make_req(CMD_TICK, '0, '0, '0));    // start of drain
        send_req(make_req(CMD_TICK, '0, '0, '0));    // still draining
        send_req(make_req(CMD_TICK, '1, '1, '0));    // neighbors not acked
        send_req(make_req(CMD_TICK, '1, '1, '1));    // drained, into testing
        send_req(make_req(CMD_TICK, '0, '0, '0));    // zero duration ends test at once
        send_req(make_req(CMD_TICK, '1, 5'b10111, '1));
        send_req(make_req(CMD_TICK, 5'b11110, '1, '1));
        send_req(make_req(CMD_TICK, '1, '1, '1));    // recovered
        send_req(make_req(CMD_TICK, 5'b10101, 5'b01010, 5'b11001));
        send_req(make_req(CMD_LOAD, '0, '1, '0));    // load while draining
        send_req(make_req(CMD_TICK, '1, '1, '1));
        wait_idle();

        // Random phases: every mode under every idle profile
        for (int ph = 0; ph < PHASES; ph++) begin
            mode      = MODE_CYCLE[2'(ph % 4)];
            intv      = TIME_W'($urandom_range(30, 1));
            dur       = TIME_W'($urandom_range(6));
            free_slot = TIME_W'($urandom_range(6));
            blk       = TIME_W'($urandom_range(6));
            offs      = OFFSET_W'($urandom_range(4095));
            rx        = COORD_W'($urandom_range(63));
            ry        = COORD_W'($urandom_range(63));
            if (ph == 5) intv = '1;
            if (ph == 10) begin
                dur       = '1;
                free_slot = '1;
                blk       = '1;
            end
            if (ph == 15) begin
                intv      = TIME_W'(1);
                dur       = '0;
                free_slot = '0;
                blk       = '0;
                offs      = '0;
                rx        = '0;
                ry        = '0;
            end
            program_schedule(mode, intv, dur, free_slot, blk, offs, rx, ry);

            case (ph / 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            // fill the block while the receiver holds off
            if (ph == 0) hold_off_req = 1'b1;

            repeat (REQS_PER_PHASE) begin
                while ($urandom_range(99) < send_idle_pct) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                end
                send_req(random_req());
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("router_bist_scheduler_top_tb OK");
        else
            $display("router_bist_scheduler_top_tb NOT OK");
        $finish;
    end

endmodule
